@@ src/plfo_tri_pkg.sv @@
`timescale 1ns / 1ps
// Package for the triangle pitch LFO: channel count, phase codes, sequencer
// states and the ceiling fix-up for the shared divider. No dependencies.
package plfo_tri_pkg;

	localparam int CHANNELS = 6;

	localparam logic [2:0] PH_DELAY  = 3'd0;
	localparam logic [2:0] PH_FALL_A = 3'd1;
	localparam logic [2:0] PH_RISE_A = 3'd2;
	localparam logic [2:0] PH_RISE_B = 3'd3;
	localparam logic [2:0] PH_FALL_B = 3'd4;

	localparam logic [7:0] QUOT_SAT = 8'hff;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_DIV_A = 5'b00100,
		ST_DIV_B = 5'b01000,
		ST_FIN   = 5'b10000
	} seq_state_t;

	// ceil(x/y) from floor quotient and remainder; zero divisor saturates unless x is zero
	function automatic logic [7:0] ceil_fix(input logic [7:0] q, input logic [7:0] r,
			input logic [7:0] x, input logic [7:0] y);
		logic [7:0] res;
		if (y == 8'd0) begin
			res = (x != 8'd0) ? QUOT_SAT : 8'd0;
		end else begin
			res = q + {7'd0, (r != 8'd0)};
		end
		return res;
	endfunction

endpackage

@@ src/pitch_lfo_triangle_unit.sv @@
`timescale 1ns / 1ps
// Triangle pitch LFO top level: channel state, sequencer, shared serial divider.
// Depends on plfo_tri_pkg.
// Each word passes through ST_CHECK and ST_FIN before its result is registered;
// the tick that ends the delay also runs two divisions, ST_DIV_A then ST_DIV_B,
// on one shared restoring divider (one quotient bit per cycle).
// A new word is taken only in ST_IDLE, once the last word has finished, and a
// finished word waits in ST_FIN for a free output register.
// Reset (arst_n low, asynchronous): all channels return to phase 0 with zeroed
// counters; no result pending.
module pitch_lfo_triangle_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] channel, [10:3] delay_ticks, [18:11] speed, [26:19] depth, [31:27] zero
	input  logic [31:0] s_tdata,
	// [0] restart
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [8:0] pitch_delta, [11:9] phase, [15:12] zero
	output logic [15:0] m_tdata
);
	import plfo_tri_pkg::*;

	seq_state_t state_q;

	logic [2:0] ch_q;
	logic       restart_q;
	logic [7:0] delay_q, speed_q, depth_q;

	logic [2:0] phase_q    [CHANNELS];
	logic [7:0] qcount_q   [CHANNELS];
	logic [7:0] scount_q   [CHANNELS];
	logic [7:0] interval_q [CHANNELS];
	logic [7:0] level_q    [CHANNELS];

	// shared divider
	logic [7:0] rem_q, quo_q, dsr_q;
	logic [2:0] cnt_q;
	logic [7:0] div_res_q;
	logic [8:0] trial, diff;
	logic       ge;
	logic [7:0] rem_n, quo_n, ceil_n, dvd;

	logic       m_valid_q;
	logic [15:0] m_data_q;

	logic       ch_ok, needs_div, out_free;
	logic [2:0] ph_cur;
	logic [7:0] qc_cur, sc_cur;
	logic [2:0] ph_nx;
	logic [7:0] qc_nx, sc_nx, qc_dec;
	logic       load_shape;
	logic [8:0] delta;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign out_free = !m_valid_q || m_tready;

	assign ch_ok  = (ch_q < 3'(CHANNELS));
	assign ph_cur = phase_q[ch_q];
	assign qc_cur = qcount_q[ch_q];
	assign sc_cur = scount_q[ch_q];
	assign needs_div = ch_ok && !restart_q && (ph_cur == PH_DELAY) && (qc_cur == 8'd0);

	// one restoring step
	assign trial = {rem_q, quo_q[7]};
	assign ge    = (trial >= {1'b0, dsr_q});
	assign diff  = trial - {1'b0, dsr_q};
	assign rem_n = ge ? diff[7:0] : trial[7:0];
	assign quo_n = {quo_q[6:0], ge};
	assign dvd   = (state_q == ST_DIV_A) ? speed_q : depth_q;
	assign ceil_n = ceil_fix(quo_n, rem_n, dvd, dsr_q);

	// per-channel update for the word in hand
	always_comb begin
		ph_nx      = ph_cur;
		qc_nx      = qc_cur;
		sc_nx      = sc_cur;
		load_shape = 1'b0;
		delta      = 9'd0;
		qc_dec     = (qc_cur != 8'd0) ? qc_cur - 8'd1 : qc_cur;
		if (restart_q) begin
			ph_nx = PH_DELAY;
			qc_nx = delay_q;
		end else if (ph_cur == PH_DELAY) begin
			if (qc_cur != 8'd0) begin
				qc_nx = qc_dec;
			end else begin
				ph_nx      = PH_FALL_A;
				qc_nx      = speed_q;
				load_shape = 1'b1;
			end
		end else if (ph_cur <= PH_FALL_B) begin
			qc_nx = qc_dec;
			if (sc_cur != 8'd0) begin
				sc_nx = sc_cur - 8'd1;
			end else begin
				if (ph_cur == PH_FALL_A || ph_cur == PH_FALL_B)
					delta = 9'd0 - {1'b0, level_q[ch_q]};
				else
					delta = {1'b0, level_q[ch_q]};
				sc_nx = interval_q[ch_q];
				if (qc_dec == 8'd0) begin
					qc_nx = speed_q;
					ph_nx = (ph_cur == PH_FALL_B) ? PH_FALL_A : ph_cur + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			cnt_q     <= 3'd0;
			for (int i = 0; i < CHANNELS; i++) begin
				phase_q[i]    <= PH_DELAY;
				qcount_q[i]   <= 8'd0;
				scount_q[i]   <= 8'd0;
				interval_q[i] <= 8'd0;
				level_q[i]    <= 8'd0;
			end
		end else begin
			if (state_q == ST_FIN && out_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					cnt_q <= 3'd0;
					state_q <= needs_div ? ST_DIV_A : ST_FIN;
				end
				ST_DIV_A: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7)
						state_q <= ST_DIV_B;
				end
				ST_DIV_B: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q   <= ST_IDLE;
						if (ch_ok) begin
							phase_q[ch_q]  <= ph_nx;
							qcount_q[ch_q] <= qc_nx;
							if (load_shape) begin
								scount_q[ch_q]   <= div_res_q;
								interval_q[ch_q] <= div_res_q;
							end else begin
								scount_q[ch_q] <= sc_nx;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// level is written as soon as the second division ends
			if (state_q == ST_DIV_B && cnt_q == 3'd7 && ch_ok)
				level_q[ch_q] <= (ceil_n == 8'd0) ? 8'd1 : ceil_n;
		end
	end

	// payload, divider and output data registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			ch_q      <= s_tdata[2:0];
			delay_q   <= s_tdata[10:3];
			speed_q   <= s_tdata[18:11];
			depth_q   <= s_tdata[26:19];
			restart_q <= s_tuser;
		end
		case (state_q)
			ST_CHECK: begin
				rem_q <= 8'd0;
				quo_q <= speed_q;
				dsr_q <= depth_q;
			end
			ST_DIV_A: begin
				if (cnt_q == 3'd7) begin
					div_res_q <= ceil_n;
					rem_q     <= 8'd0;
					quo_q     <= depth_q;
					dsr_q     <= speed_q;
				end else begin
					rem_q <= rem_n;
					quo_q <= quo_n;
				end
			end
			ST_DIV_B: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
			end
			default: begin
			end
		endcase
		if (state_q == ST_FIN && out_free) begin
			if (ch_ok)
				m_data_q <= {4'd0, ph_nx, delta};
			else
				m_data_q <= 16'd0;
		end
	end

endmodule

@@ test/tb_pitch_lfo_triangle_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pitch_lfo_triangle_unit: drives tick and restart
// words and checks each result against a built-in vibrato predictor.
// Depends on plfo_tri_pkg and the pitch_lfo_triangle_unit RTL.
module tb_pitch_lfo_triangle_unit;
	import plfo_tri_pkg::*;

	typedef struct packed {
		logic [8:0] delta;
		logic [2:0] phase;
	} lfo_result_t;

	class vibrato_scoreboard;
		logic [2:0]  phase_q    [CHANNELS];
		logic [7:0]  quarter_q  [CHANNELS];
		logic [7:0]  step_q     [CHANNELS];
		logic [7:0]  interval_q [CHANNELS];
		logic [7:0]  level_q    [CHANNELS];
		lfo_result_t pending[$];
		int          errors;

		function new();
			for (int c = 0; c < CHANNELS; c++) begin
				phase_q[c]    = PH_DELAY;
				quarter_q[c]  = 8'd0;
				step_q[c]     = 8'd0;
				interval_q[c] = 8'd0;
				level_q[c]    = 8'd0;
			end
			errors = 0;
		endfunction

		// ceiling quotient; zero dividend gives 0, zero divisor saturates
		function logic [7:0] div_up(logic [7:0] x, logic [7:0] y);
			int q;
			if (x == 8'd0)
				return 8'd0;
			if (y == 8'd0)
				return QUOT_SAT;
			q = (int'(x) + int'(y) - 1) / int'(y);
			return (q > 255) ? QUOT_SAT : q[7:0];
		endfunction

		function void note_word(logic [2:0] chan, logic restart, logic [7:0] delay,
				logic [7:0] speed, logic [7:0] depth);
			lfo_result_t r;
			logic [2:0]  ph;
			r.delta = 9'd0;
			r.phase = PH_DELAY;
			if (chan < CHANNELS) begin
				if (restart) begin
					phase_q[chan]   = PH_DELAY;
					quarter_q[chan] = delay;
				end else begin
					ph = phase_q[chan];
					if (ph == PH_DELAY) begin
						if (quarter_q[chan] != 8'd0) begin
							quarter_q[chan]--;
						end else begin
							phase_q[chan]    = PH_FALL_A;
							quarter_q[chan]  = speed;
							step_q[chan]     = div_up(speed, depth);
							interval_q[chan] = step_q[chan];
							level_q[chan]    = div_up(depth, speed);
							if (level_q[chan] == 8'd0)
								level_q[chan] = 8'd1;
						end
					end else if (ph <= PH_FALL_B) begin
						if (quarter_q[chan] != 8'd0)
							quarter_q[chan]--;
						if (step_q[chan] != 8'd0) begin
							step_q[chan]--;
						end else begin
							if (ph == PH_FALL_A || ph == PH_FALL_B)
								r.delta = 9'd0 - {1'b0, level_q[chan]};
							else
								r.delta = {1'b0, level_q[chan]};
							step_q[chan] = interval_q[chan];
							if (quarter_q[chan] == 8'd0) begin
								quarter_q[chan] = speed;
								phase_q[chan] = (ph == PH_FALL_B) ? PH_FALL_A : ph + 3'd1;
							end
						end
					end
				end
				r.phase = phase_q[chan];
			end
			pending.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			$display("ERROR at %0t: %s", $time, msg);
		endtask

		task check_result(logic [15:0] word);
			lfo_result_t exp_r;
			if (pending.size() == 0) begin
				report($sformatf("result word %h with nothing pending", word));
			end else begin
				exp_r = pending.pop_front();
				if (word[8:0] !== exp_r.delta)
					report($sformatf("pitch_delta %0d, expected %0d",
						$signed(word[8:0]), $signed(exp_r.delta)));
				if (word[11:9] !== exp_r.phase)
					report($sformatf("phase %0d, expected %0d", word[11:9], exp_r.phase));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	vibrato_scoreboard sb;
	int  tx_idle_pct = 0;
	int  rx_idle_pct = 0;
	bit  hold_req = 1'b0;
	bit  hold_done = 1'b0;
	int  live_words = 0;

	// per-channel LFO shape that random words mostly reuse
	logic [7:0] shape_delay [CHANNELS];
	logic [7:0] shape_speed [CHANNELS];
	logic [7:0] shape_depth [CHANNELS];

	pitch_lfo_triangle_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send_word(logic [2:0] chan, logic restart, logic [7:0] delay,
			logic [7:0] speed, logic [7:0] depth);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, depth, speed, delay, chan};
		s_tuser  <= restart;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_word(chan, restart, delay, speed, depth);
		if (chan < CHANNELS)
			live_words++;
	endtask

	task automatic restart_and_tick(logic [2:0] chan, logic [7:0] delay, logic [7:0] speed,
			logic [7:0] depth, int ticks);
		send_word(chan, 1'b1, delay, speed, depth);
		repeat (ticks)
			send_word(chan, 1'b0, delay, speed, depth);
	endtask

	task automatic random_word();
		logic [2:0] chan;
		logic       restart;
		if ($urandom_range(99) < 3) begin
			// unused channel numbers; the block should leave channel state alone and return a zero word
			send_word(3'($urandom_range(7, CHANNELS)), 1'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));
			return;
		end
		chan = 3'($urandom_range(CHANNELS - 1));
		if ($urandom_range(99) < 5) begin
			shape_delay[chan] = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(4));
			shape_speed[chan] = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6));
			case ($urandom_range(3))
				0: shape_depth[chan] = 8'd0;
				1: shape_depth[chan] = 8'($urandom_range(4));
				default: shape_depth[chan] = 8'($urandom);
			endcase
		end
		restart = ($urandom_range(99) < 6);
		if ($urandom_range(9) == 0)
			send_word(chan, restart, 8'($urandom), 8'($urandom), 8'($urandom));
		else
			send_word(chan, restart, shape_delay[chan], shape_speed[chan], shape_depth[chan]);
	endtask

	// result side: random stalls plus one long hold-off on request
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (hold_req && !hold_done) begin
				hold_left = 400;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin : stimulus
		int target;
		sb = new();
		for (int c = 0; c < CHANNELS; c++) begin
			shape_delay[c] = 8'd1;
			shape_speed[c] = 8'd2;
			shape_depth[c] = 8'd3;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero delay, zero divisors, saturation, extreme fields
		restart_and_tick(3'd0, 8'd0, 8'd1, 8'd1, 5);
		restart_and_tick(3'd1, 8'd1, 8'd0, 8'd0, 3);
		restart_and_tick(3'd2, 8'd0, 8'd2, 8'd0, 3);
		restart_and_tick(3'd3, 8'd0, 8'd1, 8'd255, 3);
		restart_and_tick(3'd5, 8'd255, 8'd255, 8'd255, 1);
		send_word(3'd4, 1'b0, 8'd0, 8'd0, 8'd0);
		send_word(3'd6, 1'b1, 8'd255, 8'd255, 8'd255);
		send_word(3'd7, 1'b0, 8'd255, 8'd255, 8'd255);

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					tx_idle_pct = 25;
					rx_idle_pct = 56;
				end
				1: begin
					tx_idle_pct = 56;
					rx_idle_pct = 25;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					hold_req <= 1'b1;
				end
			endcase
			target = live_words + 300;
			while (live_words < target)
				random_word();
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
